FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tcsb_pkg.sv
package tcsb_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;

    localparam int CHAR_W = 8;
    localparam int CELL_W = 2 * CHAR_W;
    localparam int POS_W  = 11;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int WIDE_W = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'd15;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_SET   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

endpackage

FILE: src/text_console_scroll_buffer_top.sv
// Text console of ROWS x COLS cells (character low byte, attribute high byte) with a cursor.
// After reset the block blanks every cell of the cell RAM before in_ready first rises.
// Transactions: printable put, newline put (row base found by repeated add of COLS), set
// cursor, read and clear; a put that scrolls goes on with the row copy and bottom-row fill.
// Reset blanking, clear, row copy and fill go through the single write port of the cell RAM,
// one cell per cycle. A new transaction is taken while a finished result still waits in the
// output register.
module text_console_scroll_buffer_top
    import tcsb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CHAR_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [POS_W-1:0]  position,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] cell_char,
    output logic [CHAR_W-1:0] cell_attr,
    output logic [POS_W-1:0]  cursor_pos,
    output logic              scrolled
);

    `include "assert_macros.svh"

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_PUT   = 10'b0000000100,
        S_NLINE = 10'b0000001000,
        S_SCOPY = 10'b0000010000,
        S_SFILL = 10'b0000100000,
        S_CLEAR = 10'b0001000000,
        S_READ  = 10'b0010000000,
        S_RWAIT = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] rb_reg, rb_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CHAR_W-1:0] attr_reg;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [CHAR_W-1:0] res_char_reg, res_char_next;
    logic [CHAR_W-1:0] res_attr_reg, res_attr_next;
    logic              scr_reg, scr_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_attr_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_scr_reg;
    logic              out_load;

    logic [CNT_W-1:0]  add_a, add_b, add_sum;
    logic [CNT_W-1:0]  cnt_inc, cnt_dec;
    logic [ADDR_W-1:0] pos_clamped;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata, mem_rdata;

    tcsb_ram #(
        .WIDTH(CELL_W),
        .DEPTH(NCELLS)
    ) u_cells (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;
    assign cursor_pos = out_pos_reg;
    assign scrolled   = out_scr_reg;

    assign add_sum = add_a + add_b;
    assign cnt_inc = cnt_reg + 1'b1;
    assign cnt_dec = cnt_reg - 1'b1;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (WIDE_W'(position) >= WIDE_W'(NCELLS))
        begin
            pos_clamped = ADDR_W'(NCELLS - 1);
        end
        else
        begin
            pos_clamped = ADDR_W'(position);
        end
    end

    // sequencer; add_a/add_b feed the shared adder
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rb_next       = rb_reg;
        cursor_next   = cursor_reg;
        addr_next     = addr_reg;
        char_next     = char_reg;
        res_char_next = res_char_reg;
        res_attr_next = res_attr_reg;
        scr_next      = scr_reg;
        add_a         = CNT_W'(cursor_reg);
        add_b         = CNT_W'(1);
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg[ADDR_W-1:0];
        mem_wdata     = {attr_reg, BLANK_CODE};
        mem_re        = 1'b0;
        mem_raddr     = addr_reg;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {ATTR_RESET, BLANK_CODE};
                cnt_next  = cnt_inc;
                if (cnt_reg == CNT_W'(NCELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    char_next     = char_code;
                    res_char_next = '0;
                    res_attr_next = '0;
                    scr_next      = 1'b0;
                    cnt_next      = '0;
                    rb_next       = '0;
                    unique case (req_t'(req_type))
                        REQ_PUT:
                        begin
                            state_next = S_PUT;
                        end
                        REQ_SET:
                        begin
                            cursor_next = pos_clamped;
                            state_next  = S_DONE;
                        end
                        REQ_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        REQ_READ:
                        begin
                            addr_next  = pos_clamped;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PUT:
            begin
                if (char_reg == NEWLINE_CODE)
                begin
                    state_next = S_NLINE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cursor_reg;
                    mem_wdata = {attr_reg, char_reg};
                    if (add_sum >= CNT_W'(NCELLS))
                    begin
                        cursor_next = ADDR_W'(NCELLS - COLS);
                        scr_next    = 1'b1;
                        state_next  = S_SCOPY;
                    end
                    else
                    begin
                        cursor_next = add_sum[ADDR_W-1:0];
                        state_next  = S_DONE;
                    end
                end
            end
            S_NLINE:
            begin
                add_a = CNT_W'(rb_reg);
                add_b = CNT_W'(COLS);
                if (add_sum <= CNT_W'(cursor_reg))
                begin
                    rb_next = add_sum[ADDR_W-1:0];
                end
                else if (add_sum >= CNT_W'(NCELLS))
                begin
                    cursor_next = ADDR_W'(NCELLS - COLS);
                    scr_next    = 1'b1;
                    state_next  = S_SCOPY;
                end
                else
                begin
                    cursor_next = add_sum[ADDR_W-1:0];
                    state_next  = S_DONE;
                end
            end
            S_SCOPY:
            begin
                // read one row ahead, write back the cell read last cycle
                add_a     = cnt_reg;
                add_b     = CNT_W'(COLS);
                mem_re    = (cnt_reg != CNT_W'(NCELLS - COLS));
                mem_raddr = add_sum[ADDR_W-1:0];
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_dec[ADDR_W-1:0];
                mem_wdata = mem_rdata;
                if (cnt_reg == CNT_W'(NCELLS - COLS))
                begin
                    state_next = S_SFILL;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            S_SFILL, S_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_inc;
                if (cnt_reg == CNT_W'(NCELLS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                res_char_next = mem_rdata[CHAR_W-1:0];
                res_attr_next = mem_rdata[CELL_W-1:CHAR_W];
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            rb_reg        <= '0;
            cursor_reg    <= '0;
            attr_reg      <= ATTR_RESET;
            scr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rb_reg        <= rb_next;
            cursor_reg    <= cursor_next;
            scr_reg       <= scr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        char_reg     <= char_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
        if (out_load)
        begin
            out_char_reg <= res_char_reg;
            out_attr_reg <= res_attr_reg;
            out_pos_reg  <= POS_W'(cursor_reg);
            out_scr_reg  <= scr_reg;
        end
    end

    `ASSERT_NOW(a_cursor_in_grid, 1'b1, cursor_reg < ADDR_W'(NCELLS), "cursor left the grid")
    `ASSERT_NOW(a_scroll_pos, out_valid && scrolled,
        cursor_pos == POS_W'(NCELLS - COLS), "scroll did not park cursor on bottom row")
    `ASSERT_NOW(a_no_idle_write, state_reg == S_IDLE, !mem_we, "cell write while idle")
    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, state_reg != S_IDLE,
        "transaction accepted but sequencer stayed idle")

endmodule

FILE: src/tcsb_ram.sv
module tcsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: dv/text_console_scroll_buffer_top_tb.sv
module text_console_scroll_buffer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcsb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 530;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] attr;
        logic [POS_W-1:0]  cursor;
        logic              scr;
    } console_result_t;

    class console_mirror;
        logic [CELL_W-1:0] cells[NCELLS];
        int                cursor;
        logic [CHAR_W-1:0] attribute;
        console_result_t   pending_results[$];
        int                errors;
        int                n_requests;
        int                n_puts;
        int                n_scrolls;
        int                n_clears;
        int                n_reads;

        function new();
            attribute = ATTR_RESET;
            cursor = 0;
            errors = 0;
            n_requests = 0;
            n_puts = 0;
            n_scrolls = 0;
            n_clears = 0;
            n_reads = 0;
            blank_cells(0, NCELLS);
        endfunction

        function void blank_cells(int first, int count);
            for (int i = first; i < first + count; i++)
                cells[i] = {attribute, BLANK_CODE};
        endfunction

        function int clamp_cell(logic [POS_W-1:0] p);
            return (int'(p) >= NCELLS) ? NCELLS - 1 : int'(p);
        endfunction

        function void note_request(req_t req, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] p);
            console_result_t r;
            r = '0;
            n_requests++;
            case (req)
                REQ_PUT:
                begin
                    n_puts++;
                    if (cursor >= NCELLS)
                        cursor = NCELLS - 1;
                    if (ch == NEWLINE_CODE)
                        cursor = (cursor / COLS + 1) * COLS;
                    else
                    begin
                        cells[cursor] = {attribute, ch};
                        cursor++;
                    end
                    if (cursor >= NCELLS)
                    begin
                        cursor -= COLS;
                        for (int i = 0; i < NCELLS - COLS; i++)
                            cells[i] = cells[i + COLS];
                        blank_cells(NCELLS - COLS, COLS);
                        r.scr = 1'b1;
                        n_scrolls++;
                    end
                end
                REQ_SET:
                    cursor = clamp_cell(p);
                REQ_CLEAR:
                begin
                    n_clears++;
                    blank_cells(0, NCELLS);
                end
                default:
                begin
                    n_reads++;
                    r.ch = cells[clamp_cell(p)][CHAR_W-1:0];
                    r.attr = cells[clamp_cell(p)][CELL_W-1:CHAR_W];
                end
            endcase
            r.cursor = POS_W'(cursor);
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 20)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(console_result_t got);
            console_result_t want;
            if (pending_results.size() == 0)
            begin
                report("result transaction with no request outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (got.ch !== want.ch)
                report($sformatf("cell_char got %0h want %0h", got.ch, want.ch));
            if (got.attr !== want.attr)
                report($sformatf("cell_attr got %0h want %0h", got.attr, want.attr));
            if (got.cursor !== want.cursor)
                report($sformatf("cursor_pos got %0d want %0d", got.cursor, want.cursor));
            if (got.scr !== want.scr)
                report($sformatf("scrolled got %0b want %0b", got.scr, want.scr));
        endtask

        task flush_leftovers();
            while (pending_results.size() != 0)
            begin
                void'(pending_results.pop_front());
                report("expected result never arrived");
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CHAR_W-1:0] cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [1:0]        req_type  = '0;
    logic [CHAR_W-1:0] char_code = '0;
    logic [POS_W-1:0]  position  = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
    logic [POS_W-1:0]  cursor_pos;
    logic              scrolled;

    console_mirror board;
    int            sender_idle_pct = 0;
    int            recv_idle_pct   = 0;
    bit            hold_request    = 1'b0;
    int            stalled_cycles  = 0;

    text_console_scroll_buffer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .char_code  (char_code),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_char  (cell_char),
        .cell_attr  (cell_attr),
        .cursor_pos (cursor_pos),
        .scrolled   (scrolled)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random backpressure, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // handshakes are judged at negedge, where everything is settled
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({cell_char, cell_attr, cursor_pos, scrolled});
    end

    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("text_console_scroll_buffer_top_tb NOT OK");
            $finish;
        end
    end

    task automatic send_request(req_t req, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] p);
        bit fire;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        char_code <= ch;
        position <= p;
        do
        begin
            @(negedge clk);
            fire = in_ready;
            if (fire)
                board.note_request(req, ch, p);
            @(posedge clk);
        end
        while (!fire);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_attribute(logic [CHAR_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        board.attribute = value;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        return ($urandom_range(3) == 0) ? NEWLINE_CODE : CHAR_W'($urandom_range(255));
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(2))
            0:       return POS_W'($urandom_range(2047));
            1:       return POS_W'($urandom_range(2047, NCELLS - 2 * COLS));
            default: return POS_W'($urandom_range(NCELLS - 1, NCELLS - 10));
        endcase
    endfunction

    task automatic put_burst(inout int sent);
        int len;
        len = $urandom_range(8, 1);
        repeat (len)
        begin
            send_request(REQ_PUT, pick_char(), '0);
            sent++;
        end
    endtask

    task automatic run_random(int items, bit with_hold);
        int sent;
        int k;
        int n;
        int p;
        sent = 0;
        while (sent < items)
        begin
            if (with_hold && sent >= items / 2 && sent < items / 2 + 4)
                hold_request = 1'b1;
            k = $urandom_range(99);
            if (k < 2)
            begin
                send_request(REQ_CLEAR, CHAR_W'($urandom_range(255)), pick_position());
                sent++;
            end
            else if (k < 40)
            begin
                send_request(REQ_SET, CHAR_W'($urandom_range(255)), pick_position());
                sent++;
                put_burst(sent);
            end
            else if (k < 50)
                put_burst(sent);
            else if (k < 85)
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                begin
                    if ($urandom_range(1))
                        p = $urandom_range(2047);
                    else
                        p = (board.cursor > 3) ? board.cursor - $urandom_range(3) : 0;
                    send_request(REQ_READ, CHAR_W'($urandom_range(255)), POS_W'(p));
                    sent++;
                end
            end
            else
            begin
                send_request(req_t'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                             POS_W'($urandom_range(2047)));
                sent++;
            end
        end
        drain();
    endtask

    task automatic run_directed();
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'hFF, 11'd1999);
        send_request(REQ_READ, 8'h00, 11'd2047);
        send_request(REQ_READ, 8'h00, 11'd2000);
        send_request(REQ_PUT, 8'h41, 11'd0);
        send_request(REQ_PUT, 8'hFF, 11'd2047);
        send_request(REQ_PUT, 8'h00, 11'd0);
        send_request(REQ_PUT, NEWLINE_CODE, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd1);
        // last cell, then a put that runs past it
        send_request(REQ_SET, 8'h00, 11'd2047);
        send_request(REQ_PUT, 8'h5A, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd1919);
        send_request(REQ_READ, 8'h00, 11'd1999);
        // newline on the bottom row
        send_request(REQ_SET, 8'h00, 11'd1925);
        send_request(REQ_PUT, NEWLINE_CODE, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_SET, 8'h00, 11'd0);
        send_request(REQ_SET, 8'h00, 11'd1024);
        send_request(REQ_SET, 8'h00, 11'd2000);
        send_request(REQ_CLEAR, 8'hFF, 11'd2047);
        send_request(REQ_READ, 8'h00, 11'd5);
        send_request(REQ_READ, 8'h00, 11'd1999);
        send_request(REQ_PUT, 8'h80, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd1999);
        drain();
    endtask

    initial
    begin
        logic [CHAR_W-1:0] mid_attr;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        write_attribute(8'h00);
        sender_idle_pct = 17;
        recv_idle_pct = 67;
        run_random(PHASE_ITEMS, 1'b0);

        write_attribute(8'hFF);
        sender_idle_pct = 67;
        recv_idle_pct = 17;
        run_random(PHASE_ITEMS, 1'b0);

        mid_attr = CHAR_W'($urandom_range(254, 1));
        write_attribute(mid_attr);
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS, 1'b1);

        board.flush_leftovers();
        $display("covered %0d requests: %0d puts (%0d scrolls), %0d clears, %0d reads",
                 board.n_requests, board.n_puts, board.n_scrolls, board.n_clears,
                 board.n_reads);
        $display("attributes 15, 0, 255 and %0d; three backpressure mixes with a long stall",
                 mid_attr);
        if (board.errors == 0)
            $display("text_console_scroll_buffer_top_tb OK");
        else
            $display("text_console_scroll_buffer_top_tb NOT OK");
        $finish;
    end

endmodule
